// File: hdl/ple_pkg.sv
// Package with the shared types and constants of the positional list engine.
package ple_pkg;

   localparam int PLE_DEPTH   = 16;
   localparam int KIND_W      = 2;
   localparam int POSITION_W  = 5;
   localparam int VALUE_W     = 32;
   localparam int COUNT_W     = 5;
   localparam int STATUS_W    = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_READ   = 2'd2,
      KIND_LAST   = 2'd3
   } ple_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } ple_status_type;

   typedef struct packed {
      ple_kind_type                kind;
      logic [POSITION_W-1:0]       position;
      logic signed [VALUE_W-1:0]   value;
   } ple_op_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]   read_value;
      logic [COUNT_W-1:0]          entry_count;
      ple_status_type              status;
   } ple_result_type;

endpackage

// File: hdl/ple_input_stage.sv
// Input register that holds one item until the list stage takes it.
module ple_input_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  ple_pkg::ple_op_type req_op,
   input  logic                advance,
   output logic                req_stall,
   output logic                op_valid,
   output ple_pkg::ple_op_type op
);
   import ple_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   ple_op_type op_ff;
   logic       load;

   // The register can load whenever it is empty or its item moves on this cycle.
   assign req_stall = valid_ff & ~advance;
   assign load      = req_valid & ~req_stall;
   assign valid_in  = load | (valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         op_ff <= req_op;
      end
   end

   assign op_valid = valid_ff;
   assign op       = op_ff;

endmodule

// File: hdl/ple_store.sv
// List storage with the shift network and the result logic for one operation.
module ple_store #(
   parameter int DEPTH = ple_pkg::PLE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  ple_pkg::ple_op_type     op,
   output ple_pkg::ple_result_type result
);
   import ple_pkg::*;

   localparam int CW   = $clog2(DEPTH + 1);
   localparam int IW   = $clog2(DEPTH);
   localparam int CMPW = (CW > POSITION_W) ? CW : POSITION_W;

   logic signed [VALUE_W-1:0] entries_ff [DEPTH];
   logic signed [VALUE_W-1:0] entries_in [DEPTH];
   logic [CW-1:0]             count_ff;
   logic [CW-1:0]             count_in;

   logic [CMPW-1:0]           pos_c;
   logic [CMPW-1:0]           cnt_c;
   logic [CMPW-1:0]           ins_pos_c;
   logic [CMPW-1:0]           new_cnt_c;
   logic [IW-1:0]             rd_idx;
   logic signed [VALUE_W-1:0] rd_data;
   logic                      full;
   logic                      in_range;
   logic                      do_insert;
   logic                      do_remove;

   assign pos_c     = CMPW'(op.position);
   assign cnt_c     = CMPW'(count_ff);
   assign full      = (cnt_c == CMPW'(DEPTH));
   assign in_range  = (pos_c < cnt_c);
   // A position at or past the end appends.
   assign ins_pos_c = (pos_c > cnt_c) ? cnt_c : pos_c;
   assign do_insert = fire & (op.kind == KIND_INSERT) & ~full;
   assign do_remove = fire & (op.kind == KIND_REMOVE) & in_range;

   assign rd_idx  = (op.kind == KIND_LAST) ? IW'(count_ff - CW'(1)) : pos_c[IW-1:0];
   assign rd_data = entries_ff[rd_idx];

   for (genvar i = 0; i < DEPTH; i++) begin : g_entry
      if (i == 0) begin : g_head
         always_comb begin
            entries_in[i] = entries_ff[i];
            if (do_insert && ins_pos_c == CMPW'(i)) begin
               entries_in[i] = op.value;
            end else if (do_remove && pos_c <= CMPW'(i) && i < DEPTH - 1) begin
               entries_in[i] = entries_ff[(i + 1) % DEPTH];
            end
         end
      end else begin : g_body
         always_comb begin
            entries_in[i] = entries_ff[i];
            if (do_insert && ins_pos_c < CMPW'(i)) begin
               entries_in[i] = entries_ff[i - 1];
            end else if (do_insert && ins_pos_c == CMPW'(i)) begin
               entries_in[i] = op.value;
            end else if (do_remove && pos_c <= CMPW'(i) && i < DEPTH - 1) begin
               entries_in[i] = entries_ff[(i + 1) % DEPTH];
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + CW'(1);
      end else if (do_remove) begin
         count_in = count_ff - CW'(1);
      end
   end

   assign new_cnt_c = CMPW'(count_in);

   always_comb begin
      result.read_value  = '0;
      result.entry_count = new_cnt_c[COUNT_W-1:0];
      result.status      = ST_OK;
      case (op.kind)
         KIND_INSERT: begin
            if (full) begin
               result.status = ST_FULL;
            end
         end
         KIND_REMOVE, KIND_READ: begin
            if (in_range) begin
               result.read_value = rd_data;
            end else begin
               result.status = ST_RANGE;
            end
         end
         KIND_LAST: begin
            if (count_ff == '0) begin
               result.read_value = '1;
               result.status     = ST_EMPTY;
            end else begin
               result.read_value = rd_data;
            end
         end
         default: begin
            result.status = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         entries_ff[i] <= entries_in[i];
      end
   end

endmodule

// File: hdl/positional_list_engine.sv
// Top level of the positional list engine: input register, list stage, result register.
// Items pass from the input register through the list stage into the result register.
// Throughput: one item per cycle unless rsp_stall holds a full result register; every
// operation finishes in the single list stage. Insert and remove shift the register array through per-entry muxes.
// Reset clears the entry count and both valid flags; entry contents are not cleared.
// The block accepts items as soon as reset is released.
module positional_list_engine #(
   parameter int DEPTH = ple_pkg::PLE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [ple_pkg::KIND_W-1:0]            req_kind,
   input  logic [ple_pkg::POSITION_W-1:0]        req_position,
   input  logic signed [ple_pkg::VALUE_W-1:0]    req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [ple_pkg::VALUE_W-1:0]    rsp_read_value,
   output logic [ple_pkg::COUNT_W-1:0]           rsp_entry_count,
   output logic [ple_pkg::STATUS_W-1:0]          rsp_status
);
   import ple_pkg::*;

   ple_op_type     req_op;
   ple_op_type     op;
   logic           op_valid;
   logic           advance;
   ple_result_type result;
   ple_result_type rsp_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;

   assign req_op.kind     = ple_kind_type'(req_kind);
   assign req_op.position = req_position;
   assign req_op.value    = req_value;

   // The list stage moves an item whenever the result register is free or being drained.
   assign advance      = op_valid & (~rsp_valid_ff | ~rsp_stall);
   assign rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);

   ple_input_stage u_input (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .advance   (advance),
      .req_stall (req_stall),
      .op_valid  (op_valid),
      .op        (op)
   );

   ple_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .op     (op),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_ff.read_value;
   assign rsp_entry_count = rsp_ff.entry_count;
   assign rsp_status      = rsp_ff.status;

endmodule

// File: dv/list_check_pkg.sv
// Scoreboard class that predicts and checks the results of the positional list engine.
package list_check_pkg;

   import ple_pkg::*;

   class list_scoreboard;
      logic signed [VALUE_W-1:0] list_vals [PLE_DEPTH];
      int                        list_len;
      ple_result_type            pending_results [$];
      int unsigned               error_count;
      int unsigned               checked_count;
      int unsigned               status_seen [4];

      function new();
         list_len      = 0;
         error_count   = 0;
         checked_count = 0;
         foreach (status_seen[s]) status_seen[s] = 0;
      endfunction

      // Apply one accepted item to the local copy of the list and queue its result.
      function void note_op(ple_kind_type kind, logic [POSITION_W-1:0] pos,
                            logic signed [VALUE_W-1:0] val);
         ple_result_type res;
         int             p;
         int             i;
         res.read_value = '0;
         res.status     = ST_OK;
         p = int'(pos);
         case (kind)
            KIND_INSERT: begin
               if (list_len >= PLE_DEPTH) begin
                  res.status = ST_FULL;
               end else begin
                  // Any position at or past the end appends.
                  if (p > list_len) p = list_len;
                  for (i = list_len; i > p; i--) list_vals[i] = list_vals[i-1];
                  list_vals[p] = val;
                  list_len++;
               end
            end
            KIND_REMOVE: begin
               if (p >= list_len) begin
                  res.status = ST_RANGE;
               end else begin
                  res.read_value = list_vals[p];
                  for (i = p; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
                  list_len--;
               end
            end
            KIND_READ: begin
               if (p >= list_len) res.status = ST_RANGE;
               else res.read_value = list_vals[p];
            end
            default: begin
               if (list_len == 0) begin
                  res.read_value = '1;
                  res.status     = ST_EMPTY;
               end else begin
                  res.read_value = list_vals[list_len-1];
               end
            end
         endcase
         res.entry_count = COUNT_W'(list_len);
         pending_results.insert(pending_results.size(), res);
      endfunction

      function void check_result(logic signed [VALUE_W-1:0] got_value,
                                 logic [COUNT_W-1:0] got_count,
                                 logic [STATUS_W-1:0] got_status);
         ple_result_type exp_res;
         if (pending_results.size() == 0) begin
            $error("result with no item outstanding: read_value %0d, entry_count %0d, status %0d",
                   got_value, got_count, got_status);
            error_count++;
            return;
         end
         exp_res = pending_results.pop_front();
         checked_count++;
         status_seen[exp_res.status]++;
         if (exp_res.read_value !== got_value) begin
            $error("read_value mismatch: expected %0d, got %0d", exp_res.read_value, got_value);
            error_count++;
         end
         if (exp_res.entry_count !== got_count) begin
            $error("entry_count mismatch: expected %0d, got %0d", exp_res.entry_count, got_count);
            error_count++;
         end
         if (exp_res.status !== got_status) begin
            $error("status mismatch: expected %0d, got %0d", exp_res.status, got_status);
            error_count++;
         end
      endfunction
   endclass

endpackage

// File: dv/testbench.sv
// Self-checking testbench of the positional list engine with random traffic and stalls.
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import ple_pkg::*;
   import list_check_pkg::*;

   localparam int RANDOM_ITEMS = 1850;
   localparam int LONG_HOLD    = 120;
   localparam int CYCLE_LIMIT  = 400000;

   typedef enum {MODE_FILL, MODE_DRAIN, MODE_EVEN} traffic_mode_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [KIND_W-1:0]             req_kind;
   logic [POSITION_W-1:0]         req_position;
   logic signed [VALUE_W-1:0]     req_value;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [VALUE_W-1:0]     rsp_read_value;
   logic [COUNT_W-1:0]            rsp_entry_count;
   logic [STATUS_W-1:0]           rsp_status;

   list_scoreboard sb = new();

   bit          tx_idle_on   = 1'b1;
   bit          rx_idle_on   = 1'b1;
   bit          hold_off_req = 1'b0;
   int unsigned sent_count   = 0;

   positional_list_engine uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_value  (rsp_read_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_status      (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("** positional_list_engine: FAILED **");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_read_value, rsp_entry_count, rsp_status);
      end
   end

   // Result side: random stall bursts, free stretches, and one long hold-off on request.
   initial begin
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_stall = 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            hold_off_req = 1'b0;
         end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end else begin
            rsp_stall = 1'b0;
            repeat ($urandom_range(1, rx_idle_on ? 30 : 1)) @(negedge clock);
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic offer_op(input ple_kind_type kind, input int unsigned pos,
                           input logic signed [VALUE_W-1:0] val);
      req_valid    = 1'b1;
      req_kind     = kind;
      req_position = POSITION_W'(pos);
      req_value    = val;
      do @(posedge clock); while (req_stall);
      sb.note_op(kind, req_position, val);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic sender_gap(input int unsigned cycles);
      req_valid    = 1'b0;
      req_kind     = KIND_W'($urandom_range(0, 3));
      req_position = POSITION_W'($urandom());
      req_value    = $urandom();
      repeat (cycles) @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (sb.pending_results.size() != 0) @(negedge clock);
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh7fff_ffff;
         1:       return 32'sh8000_0000;
         2:       return -32'sd1;
         3:       return '0;
         default: return $urandom();
      endcase
   endfunction

   function automatic ple_kind_type choose_kind(traffic_mode_type mode);
      int unsigned roll;
      int unsigned ins_lim;
      int unsigned rem_lim;
      roll = $urandom_range(0, 99);
      case (mode)
         MODE_FILL:  begin ins_lim = 55; rem_lim = 70; end
         MODE_DRAIN: begin ins_lim = 20; rem_lim = 65; end
         default:    begin ins_lim = 35; rem_lim = 60; end
      endcase
      if (roll < ins_lim) return KIND_INSERT;
      if (roll < rem_lim) return KIND_REMOVE;
      if (roll < 88) return KIND_READ;
      return KIND_LAST;
   endfunction

   initial begin : stimulus
      traffic_mode_type mode;
      int               mode_end;
      int               n;
      int unsigned      pos;
      ple_kind_type     kind;

      reset        = 1'b1;
      req_valid    = 1'b0;
      req_kind     = KIND_INSERT;
      req_position = '0;
      req_value    = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Empty list: read-last, remove and read all flagged.
      offer_op(KIND_LAST, 31, 32'sh1234_5678);
      offer_op(KIND_REMOVE, 0, 0);
      offer_op(KIND_READ, 31, 0);
      // Fill to capacity, with appends past the end and inserts at the front and middle.
      offer_op(KIND_INSERT, 31, 32'sh7fff_ffff);
      offer_op(KIND_INSERT, 0, 32'sh8000_0000);
      offer_op(KIND_INSERT, 1, -32'sd1);
      offer_op(KIND_INSERT, 16, 0);
      offer_op(KIND_INSERT, 2, 32'sh5555_5555);
      offer_op(KIND_INSERT, 5, 32'shaaaa_aaaa);
      for (n = 0; n < 10; n++) offer_op(KIND_INSERT, $urandom_range(0, 31), pick_value());
      offer_op(KIND_INSERT, 3, 32'sh0bad_f00d);
      offer_op(KIND_READ, 15, 0);
      offer_op(KIND_READ, 16, 0);
      offer_op(KIND_LAST, 0, 0);
      offer_op(KIND_REMOVE, 16, 0);
      offer_op(KIND_REMOVE, 0, 0);
      offer_op(KIND_REMOVE, 14, 0);
      offer_op(KIND_READ, 0, 0);
      wait_drained();

      mode     = MODE_FILL;
      mode_end = $urandom_range(30, 120);
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == mode_end) begin
            mode     = traffic_mode_type'($urandom_range(0, 2));
            mode_end = n + $urandom_range(30, 120);
         end
         // The sender keeps offering while the result side holds off, so the block backs up.
         if (n == 400) hold_off_req = 1'b1;
         if (n == 900) wait_drained();
         if (n == RANDOM_ITEMS - 300) begin
            tx_idle_on = 1'b0;
            rx_idle_on = 1'b0;
         end
         if (tx_idle_on && $urandom_range(0, 5) == 0) sender_gap($urandom_range(1, 9));
         kind = choose_kind(mode);
         if ($urandom_range(0, 7) == 0) pos = $urandom_range(0, 31);
         else pos = $urandom_range(0, sb.list_len);
         offer_op(kind, pos, pick_value());
      end

      wait_drained();
      repeat (8) @(negedge clock);
      $display("%0d items sent, %0d results checked", sent_count, sb.checked_count);
      $display("flagged results: %0d out of range, %0d full, %0d empty",
               sb.status_seen[ST_RANGE], sb.status_seen[ST_FULL], sb.status_seen[ST_EMPTY]);
      if (sb.error_count == 0) begin
         $display("** positional_list_engine: PASSED **");
      end else begin
         $display("** positional_list_engine: FAILED **");
      end
      $finish;
   end

endmodule
